// ===== rtl/core/pbnc_pkg.sv =====
package pbnc_pkg;

    // widths fixed by the item format
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int THRESH_W   = 9;
    localparam int MAXC_W     = 7;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 9;

    // squared distance fits 18 bits (3 * 255^2 < 2^18), its root fits 9 bits
    localparam int SQ_W        = 18;
    localparam int DIST_W      = 9;
    localparam int SQRT_STEPS  = SQ_W / 2;

    localparam int DEF_PALETTE_SIZE = 64;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd7;
    localparam logic [MAXC_W-1:0]   MAXC_RESET   = 7'd50;

    // configuration register indexes
    localparam logic CFG_THRESHOLD  = 1'b0;
    localparam logic CFG_MAX_COLORS = 1'b1;

    // commands
    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SIMILAR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // sideband that travels with each palette read through the distance pipe
    typedef struct packed {
        logic valid;
        logic last;
    } pbnc_tag_t;

endpackage

// ===== rtl/core/pbnc_ram.sv =====
module pbnc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/pbnc_dist.sv =====
module pbnc_dist
    import pbnc_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pbnc_tag_t         in_tag,
    input  logic [IDX_W-1:0]  in_index,
    input  logic [RGB_W-1:0]  pix_color,
    input  logic [RGB_W-1:0]  ent_color,
    output pbnc_tag_t         out_tag,
    output logic [IDX_W-1:0]  out_index,
    output logic [DIST_W-1:0] out_dist
);

    // stage 0: abs differences, stage 1: sum of squares, then one root bit per stage
    localparam int STAGES = SQRT_STEPS + 2;

    pbnc_tag_t        tag_reg [0:STAGES-1];
    logic [IDX_W-1:0] idx_reg [0:STAGES-1];

    logic [COLOR_W-1:0] dr_reg, dg_reg, db_reg;
    logic [COLOR_W-1:0] dr_next, dg_next, db_next;
    logic [SQ_W-1:0]    sq_next;

    logic [SQ_W-1:0] rem_reg  [0:SQRT_STEPS];
    logic [SQ_W-1:0] root_reg [0:SQRT_STEPS];
    logic [SQ_W-1:0] rem_next  [0:SQRT_STEPS-1];
    logic [SQ_W-1:0] root_next [0:SQRT_STEPS-1];

    function automatic logic [COLOR_W-1:0] absdiff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        dr_next = absdiff(pix_color[RGB_W-1 -: COLOR_W], ent_color[RGB_W-1 -: COLOR_W]);
        dg_next = absdiff(pix_color[2*COLOR_W-1 -: COLOR_W], ent_color[2*COLOR_W-1 -: COLOR_W]);
        db_next = absdiff(pix_color[COLOR_W-1:0], ent_color[COLOR_W-1:0]);
        sq_next = (SQ_W'(dr_reg) * SQ_W'(dr_reg)) + (SQ_W'(dg_reg) * SQ_W'(dg_reg)) +
                  (SQ_W'(db_reg) * SQ_W'(db_reg));
    end

    // digit-by-digit integer root, one step per stage
    always_comb begin
        logic [SQ_W:0] bitv;
        logic [SQ_W:0] trial;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            bitv  = (SQ_W+1)'(1) << (SQ_W - 2 - 2 * k);
            trial = {1'b0, root_reg[k]} + bitv;
            if ({1'b0, rem_reg[k]} >= trial) begin
                rem_next[k]  = rem_reg[k] - trial[SQ_W-1:0];
                root_next[k] = (root_reg[k] >> 1) + bitv[SQ_W-1:0];
            end else begin
                rem_next[k]  = rem_reg[k];
                root_next[k] = root_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STAGES; s++) begin
                tag_reg[s] <= '0;
            end
        end else begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < STAGES; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
        idx_reg[0] <= in_index;
        for (int s = 1; s < STAGES; s++) begin
            idx_reg[s] <= idx_reg[s-1];
        end
        dr_reg      <= dr_next;
        dg_reg      <= dg_next;
        db_reg      <= db_next;
        rem_reg[0]  <= sq_next;
        root_reg[0] <= '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            rem_reg[k+1]  <= rem_next[k];
            root_reg[k+1] <= root_next[k];
        end
    end

    assign out_tag   = tag_reg[STAGES-1];
    assign out_index = idx_reg[STAGES-1];
    assign out_dist  = root_reg[SQRT_STEPS][DIST_W-1:0];

endmodule

// ===== rtl/core/palette_build_and_nearest_color_map.sv =====
// Palette builder and nearest-color mapper. Each input word carries a command and an RGB
// color. An offer word adds its color to the stored palette unless the palette already
// holds min(max_colors, PALETTE_SIZE) entries (status 2) or some stored entry lies at a
// floored Euclidean distance of at most similarity_threshold (status 1); its result
// echoes the color. A map word returns the stored entry with the smallest floored
// distance, lowest index on ties, black on an empty palette, always with status 0.
// palette_count reports the number of entries after the word. Items are handled one at
// a time: with n stored entries, an item makes one palette memory read per cycle feeding
// an 11-stage distance pipeline (abs difference, sum of squares, nine root steps), and
// map words then re-read the winning entry in FETCH and LOAD. An offer refused as full
// or any word on an empty palette skips the scan. A new word is taken while the
// previous result still waits in the output register. Registers are to be written
// through cfg_we/cfg_index/cfg_data only while the block is idle; nothing enforces it.
module palette_build_and_nearest_color_map
    import pbnc_pkg::*;
#(
    parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [COLOR_W-1:0]    s_red_in,
    input  logic [COLOR_W-1:0]    s_green_in,
    input  logic [COLOR_W-1:0]    s_blue_in,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COLOR_W-1:0]    m_red_out,
    output logic [COLOR_W-1:0]    m_green_out,
    output logic [COLOR_W-1:0]    m_blue_out,
    output logic [STATUS_W-1:0]   m_status,
    output logic [COUNT_W-1:0]    m_palette_count
);

    localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
    localparam int CMP_W = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_LOAD,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [THRESH_W-1:0] thresh_reg;
    logic [MAXC_W-1:0]   maxc_reg;

    // item context
    logic               cmd_reg, cmd_next;
    logic [RGB_W-1:0]   pix_reg, pix_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    pbnc_tag_t          rd_tag_reg, rd_tag_next;
    logic [IDX_W-1:0]   rd_index_reg, rd_index_next;
    logic               similar_reg, similar_next;
    logic [DIST_W-1:0]  best_d_reg, best_d_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [RGB_W-1:0]   res_color_reg, res_color_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic               add_reg, add_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [RGB_W-1:0]    m_color_reg, m_color_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    // palette memory port
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [RGB_W-1:0] ram_wdata, ram_rdata;

    // distance pipe output
    pbnc_tag_t         d_tag;
    logic [IDX_W-1:0]  d_index;
    logic [DIST_W-1:0] d_dist;

    logic full;
    logic issue;
    logic hit;
    logic better;

    pbnc_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pbnc_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tag    (rd_tag_reg),
        .in_index  (rd_index_reg),
        .pix_color (pix_reg),
        .ent_color (ram_rdata),
        .out_tag   (d_tag),
        .out_index (d_index),
        .out_dist  (d_dist)
    );

    assign s_ready = (state_reg == ST_IDLE);

    // full when count reaches max_colors or the memory depth
    assign full = (CMP_W'(count_reg) >= CMP_W'(maxc_reg)) ||
                  (count_reg >= CNT_W'(PALETTE_SIZE));

    assign issue  = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
    assign hit    = (d_dist <= thresh_reg);
    assign better = (d_index == '0) || (d_dist < best_d_reg);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pix_next        = pix_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rd_tag_next     = '0;
        rd_index_next   = rd_idx_reg[IDX_W-1:0];
        similar_next    = similar_reg;
        best_d_next     = best_d_reg;
        best_idx_next   = best_idx_reg;
        res_color_next  = res_color_reg;
        res_status_next = res_status_reg;
        add_next        = add_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_color_next    = m_color_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_W-1:0];
        ram_wdata       = res_color_reg;
        ram_re          = 1'b0;
        ram_raddr       = rd_idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_command;
                    pix_next     = {s_red_in, s_green_in, s_blue_in};
                    similar_next = 1'b0;
                    rd_idx_next  = '0;
                    if ((s_command == CMD_OFFER) && full) begin
                        // refused without a similarity scan
                        res_color_next  = {s_red_in, s_green_in, s_blue_in};
                        res_status_next = STATUS_FULL;
                        add_next        = 1'b0;
                        state_next      = ST_DONE;
                    end else if (count_reg == '0) begin
                        // empty palette: offer goes straight in, map gives black
                        res_color_next  = (s_command == CMD_OFFER) ?
                                          {s_red_in, s_green_in, s_blue_in} : '0;
                        res_status_next = STATUS_OK;
                        add_next        = (s_command == CMD_OFFER);
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // one palette read per cycle
                ram_re            = issue;
                rd_tag_next.valid = issue;
                rd_tag_next.last  = issue && ((rd_idx_reg + CNT_W'(1)) == count_reg);
                if (issue) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                // collect distances as they leave the pipe
                if (d_tag.valid) begin
                    if (cmd_reg == CMD_OFFER) begin
                        similar_next = similar_reg || hit;
                    end else if (better) begin
                        best_d_next   = d_dist;
                        best_idx_next = d_index;
                    end
                    if (d_tag.last) begin
                        if (cmd_reg == CMD_OFFER) begin
                            res_color_next  = pix_reg;
                            res_status_next = (similar_reg || hit) ? STATUS_SIMILAR : STATUS_OK;
                            add_next        = !(similar_reg || hit);
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_FETCH;
                        end
                    end
                end
            end

            ST_FETCH: begin
                // re-read the winning entry
                ram_re     = 1'b1;
                ram_raddr  = best_idx_reg;
                state_next = ST_LOAD;
            end

            ST_LOAD: begin
                res_color_next  = ram_rdata;
                res_status_next = STATUS_OK;
                add_next        = 1'b0;
                state_next      = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_color_next  = res_color_reg;
                    m_status_next = res_status_reg;
                    if (add_reg) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    m_count_next = COUNT_W'(add_reg ? (count_reg + CNT_W'(1)) : count_reg);
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_tag_reg  <= '0;
            m_valid_reg <= 1'b0;
            thresh_reg  <= THRESH_RESET;
            maxc_reg    <= MAXC_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_tag_reg  <= rd_tag_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_THRESHOLD:  thresh_reg <= cfg_data[THRESH_W-1:0];
                    CFG_MAX_COLORS: maxc_reg   <= cfg_data[MAXC_W-1:0];
                    default:        thresh_reg <= thresh_reg;
                endcase
            end
        end
        cmd_reg        <= cmd_next;
        pix_reg        <= pix_next;
        rd_idx_reg     <= rd_idx_next;
        rd_index_reg   <= rd_index_next;
        similar_reg    <= similar_next;
        best_d_reg     <= best_d_next;
        best_idx_reg   <= best_idx_next;
        res_color_reg  <= res_color_next;
        res_status_reg <= res_status_next;
        add_reg        <= add_next;
        m_color_reg    <= m_color_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_red_out       = m_color_reg[RGB_W-1 -: COLOR_W];
    assign m_green_out     = m_color_reg[2*COLOR_W-1 -: COLOR_W];
    assign m_blue_out      = m_color_reg[COLOR_W-1:0];
    assign m_status        = m_status_reg;
    assign m_palette_count = m_count_reg;

    // palette never holds more entries than the memory depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(PALETTE_SIZE))
        else $error("palette count beyond memory depth");

    // count only ever grows by one entry at a time
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("palette count jumped");

    // palette writes only when a result is handed to the output register
    a_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == ST_DONE) && (cmd_reg == CMD_OFFER) && m_valid_next))
        else $error("palette written outside completion");

    // distance results only arrive while scanning
    a_pipe_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        d_tag.valid |-> (state_reg == ST_SCAN))
        else $error("distance result outside scan");

    // a new result appears only after completion
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result word without completion");

endmodule
